[hw/rtl/sabr_pkg.sv]
package sabr_pkg;

  localparam int unsigned DrawW = 16;
  localparam int unsigned ValW = 32;
  localparam int unsigned BetaW = 17;
  localparam int unsigned NuW = 20;
  localparam int unsigned ScaleW = 17;
  localparam int unsigned CntW = 16;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [ValW-1:0] FLOOR_Q16 = 32'd66;
  localparam logic [ValW-1:0] MAX_Q16 = 32'hFFFF_FFFF;
  localparam logic [BetaW-1:0] BETA_ONE = 17'd65536;

  localparam logic [CfgIdxW-1:0] REG_INIT_FWD = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_INIT_VOL = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_BETA = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_NU = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_SCALE = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_STEPS = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_PATHS = 3'd6;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_NORM,
    ST_LOG,
    ST_LOGMUL,
    ST_EXP,
    ST_EXPSH,
    ST_FM1,
    ST_FM2,
    ST_FM3,
    ST_VM1,
    ST_VM2,
    ST_VM3,
    ST_SETTLE,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic signed [DrawW-1:0] draw_forward;
    logic signed [DrawW-1:0] draw_vol;
  } draw_t;

  typedef struct packed {
    logic [ValW-1:0] forward_out;
    logic [ValW-1:0] vol_out;
    logic path_last;
    logic all_last;
  } result_t;

  typedef struct packed {
    logic [CfgIdxW-1:0] index;
    logic [ValW-1:0] data;
  } cfg_t;

  function automatic logic [31:0] exp2_const(input logic [3:0] k);
    logic [31:0] c;
    case (k)
      4'd0: c = 32'd1518500250;
      4'd1: c = 32'd1276901417;
      4'd2: c = 32'd1170923762;
      4'd3: c = 32'd1121280436;
      4'd4: c = 32'd1097253709;
      4'd5: c = 32'd1085434104;
      4'd6: c = 32'd1079142639;
      4'd7: c = 32'd1076653033;
      4'd8: c = 32'd1075196443;
      4'd9: c = 32'd1074468888;
      4'd10: c = 32'd1074105294;
      4'd11: c = 32'd1073923544;
      4'd12: c = 32'd1073832680;
      4'd13: c = 32'd1073787251;
      4'd14: c = 32'd1073764537;
      default: c = 32'd1073753181;
    endcase
    return c;
  endfunction

endpackage

[hw/rtl/sabr_if.sv]
interface sabr_if #(
  parameter type payload_t = logic
);
  logic valid;
  logic ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[hw/rtl/sabr_euler_path_step_top.sv]
// SABR Euler-Maruyama path stepper.
// draws (sink): one pair of Q3.12 normal draws per time step. A transfer
//   starts one step; ready stays low until that step's result is loaded
//   into the output register.
// results (source): new forward and volatility (Q16.16), path_last and
//   all_last. The result register holds while the receiver stalls; the
//   next draw pair may be taken while a result still waits, and that step
//   then holds before its result load until the waiting result transfers.
// cfg (sink): register writes by index, always ready; write only while
//   the stepper is idle. Initial values apply at the next path reload.
// Steps: the forward is normalized, one left shift per leading zero, then
//   the shared 33x32 multiplier does 16 squarings for log2, one beta
//   product, 16 exp2 steps, then three products for each drift term; a
//   zero forward skips the log2 and exp2 steps.
// A draw pair is taken only after the step before it has made its result valid.
// Reset: config registers return to their reset values, state reloads the
//   initial forward and volatility, step and path counters clear.
module sabr_euler_path_step_top (
  input logic clk,
  input logic rst,
  sabr_if.sink draws,
  sabr_if.source results,
  sabr_if.sink cfg
);
  import sabr_pkg::*;

  logic [ValW-1:0] init_fwd, init_vol;
  logic [BetaW-1:0] beta;
  logic [NuW-1:0] nu;
  logic [ScaleW-1:0] scale;
  logic [CntW-1:0] steps, paths;

  logic [ValW-1:0] fwd_now, vol_now;
  logic [CntW-1:0] step_idx, path_idx;

  state_t state, state_next;

  logic signed [DrawW-1:0] z1, z2;
  logic [4:0] cnt;
  logic [5:0] msb;
  logic [32:0] x;
  logic [15:0] frac;
  logic [21:0] vexp;
  logic [31:0] acc;
  logic [ValW-1:0] fb, m;
  logic [34:0] dmag_f, dmag_v;

  logic out_valid;
  logic out_free;
  result_t out_reg;

  // shared multiplier
  logic [32:0] mul_a;
  logic [31:0] mul_b;
  logic [64:0] mul_p;
  assign mul_p = mul_a * mul_b;

  logic [BetaW-1:0] beta_c;
  assign beta_c = (beta > BETA_ONE) ? BETA_ONE : beta;

  assign cfg.ready = 1'b1;
  assign draws.ready = (state == ST_IDLE);
  assign results.valid = out_valid;
  assign results.data = out_reg;
  assign out_free = !out_valid || results.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      init_fwd <= 32'd65536;
      init_vol <= 32'd13107;
      beta <= 17'd32768;
      nu <= 20'd26214;
      scale <= 17'd6554;
      steps <= 16'd100;
      paths <= 16'd1;
    end else if (cfg.valid) begin
      case (cfg.data.index)
        REG_INIT_FWD: init_fwd <= cfg.data.data;
        REG_INIT_VOL: init_vol <= cfg.data.data;
        REG_BETA: beta <= cfg.data.data[BetaW-1:0];
        REG_NU: nu <= cfg.data.data[NuW-1:0];
        REG_SCALE: scale <= cfg.data.data[ScaleW-1:0];
        REG_STEPS: steps <= cfg.data.data[CntW-1:0];
        REG_PATHS: paths <= cfg.data.data[CntW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  logic exp_done;
  assign exp_done = (cnt == 5'd16);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (draws.valid && draws.ready) state_next = ST_NORM;
      ST_NORM: begin
        if (fwd_now == '0) state_next = ST_FM1;
        else if (x[31]) state_next = ST_LOG;
      end
      ST_LOG: if (cnt == 5'd15) state_next = ST_LOGMUL;
      ST_LOGMUL: state_next = ST_EXP;
      ST_EXP: if (exp_done) state_next = ST_EXPSH;
      ST_EXPSH: state_next = ST_FM1;
      ST_FM1: state_next = ST_FM2;
      ST_FM2: state_next = ST_FM3;
      ST_FM3: state_next = ST_VM1;
      ST_VM1: state_next = ST_VM2;
      ST_VM2: state_next = ST_VM3;
      ST_VM3: state_next = ST_SETTLE;
      ST_SETTLE: if (out_free) state_next = ST_OUT;
      ST_OUT: if (!out_valid) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // multiplier operand select
  always_comb begin
    mul_a = x;
    mul_b = x[31:0];
    case (state)
      ST_LOG: begin mul_a = x; mul_b = x[31:0]; end
      ST_LOGMUL: begin mul_a = {12'd0, msb[4:0], frac}; mul_b = {15'd0, beta_c}; end
      ST_EXP: begin mul_a = {1'b0, acc}; mul_b = exp2_const(cnt[3:0]); end
      ST_FM1: begin mul_a = {1'b0, vol_now}; mul_b = fb; end
      ST_FM2, ST_VM2: begin mul_a = {1'b0, m}; mul_b = {15'd0, scale}; end
      ST_FM3: begin
        mul_a = {1'b0, m};
        mul_b = {16'd0, z1[DrawW-1] ? 16'(-z1) : 16'(z1)};
      end
      ST_VM1: begin mul_a = {13'd0, nu}; mul_b = vol_now; end
      ST_VM3: begin
        mul_a = {1'b0, m};
        mul_b = {16'd0, z2[DrawW-1] ? 16'(-z2) : 16'(z2)};
      end
      default: ;
    endcase
  end

  function automatic logic [31:0] sat_q16(input logic [64:0] p);
    return (|p[64:48]) ? MAX_Q16 : p[47:16];
  endfunction

  logic [33:0] x_sq;
  assign x_sq = mul_p[64:31];

  logic [22:0] vcalc;
  assign vcalc = 23'(mul_p[36:16]) + 23'(1 << 20) - 23'({beta_c, 4'd0});

  logic signed [7:0] sh;
  assign sh = $signed({2'b00, vexp[21:16]}) - 8'sd30;

  // exp2 mantissa shifted up; the shift never exceeds 1
  logic [47:0] acc_sh;
  assign acc_sh = {16'd0, acc} << sh[4:0];

  logic signed [36:0] f_sum, v_sum;
  assign f_sum = z1[DrawW-1] ? $signed({5'b0, fwd_now}) - $signed({2'b0, dmag_f})
                             : $signed({5'b0, fwd_now}) + $signed({2'b0, dmag_f});
  assign v_sum = z2[DrawW-1] ? $signed({5'b0, vol_now}) - $signed({2'b0, dmag_v})
                             : $signed({5'b0, vol_now}) + $signed({2'b0, dmag_v});

  function automatic logic [31:0] settle(input logic signed [36:0] s);
    if (s < $signed({5'b0, FLOOR_Q16})) return FLOOR_Q16;
    if (s[36:32] != 5'b00000) return MAX_Q16;
    return s[31:0];
  endfunction

  logic plast, alast;
  assign plast = (17'(step_idx) + 17'd1) >= 17'(steps);
  assign alast = plast && ((17'(path_idx) + 17'd1) >= 17'(paths));

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_now <= 32'd65536;
      vol_now <= 32'd13107;
      step_idx <= '0;
      path_idx <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && results.ready) out_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (draws.valid && draws.ready) begin
            z1 <= draws.data.draw_forward;
            z2 <= draws.data.draw_vol;
            x <= {1'b0, fwd_now};
            msb <= 6'd31;
            cnt <= '0;
            frac <= '0;
            acc <= 32'h4000_0000;
            fb <= (beta_c == '0) ? 32'd65536 : 32'd0;
          end
        end
        ST_NORM: begin
          // shift left one bit a cycle until the leading one reaches bit 31
          if (fwd_now != '0) begin
            if (!x[31]) begin
              x <= {x[31:0], 1'b0};
              msb <= msb - 6'd1;
            end else begin
              msb <= {1'b0, msb[4:0]};
            end
          end
        end
        ST_LOG: begin
          cnt <= cnt + 5'd1;
          if (x_sq[32]) begin
            x <= x_sq[33:1];
            frac <= {frac[14:0], 1'b1};
          end else begin
            x <= x_sq[32:0];
            frac <= {frac[14:0], 1'b0};
          end
        end
        ST_LOGMUL: begin
          vexp <= vcalc[21:0];
          cnt <= '0;
        end
        ST_EXP: begin
          if (!exp_done) begin
            cnt <= cnt + 5'd1;
            if (vexp[15 - cnt[3:0]]) acc <= mul_p[61:30];
          end
        end
        ST_EXPSH: begin
          // n - 14 where n = int(v) - 16
          if (sh >= 0) begin
            if (sh > 8'sd32) fb <= MAX_Q16;
            else fb <= (|acc_sh[47:32]) ? MAX_Q16 : acc_sh[31:0];
          end else begin
            fb <= (sh < -8'sd62) ? 32'd0 : 32'({acc} >> (-sh));
          end
        end
        ST_FM1, ST_FM2, ST_VM1, ST_VM2: m <= sat_q16(mul_p);
        ST_FM3: dmag_f <= mul_p[46:12];
        ST_VM3: dmag_v <= mul_p[46:12];
        ST_SETTLE: begin
          // hold until the output register is free or transfers now
          if (out_free) begin
            out_reg.forward_out <= settle(f_sum);
            out_reg.vol_out <= settle(v_sum);
            out_reg.path_last <= plast;
            out_reg.all_last <= alast;
          end
        end
        ST_OUT: begin
          if (!out_valid) begin
            out_valid <= 1'b1;
            if (out_reg.path_last) begin
              fwd_now <= init_fwd;
              vol_now <= init_vol;
              step_idx <= '0;
              path_idx <= out_reg.all_last ? '0 : path_idx + 16'd1;
            end else begin
              fwd_now <= out_reg.forward_out;
              vol_now <= out_reg.vol_out;
              step_idx <= step_idx + 16'd1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    (draws.valid && draws.ready) |=> (state == ST_NORM))
    else $error("draw transfer did not start a step");
  assert property (@(posedge clk) disable iff (rst)
    (results.valid && !results.ready) |=> $stable(results.data))
    else $error("result changed while stalled");
  assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> !draws.ready)
    else $error("ready while busy");
  assert property (@(posedge clk) disable iff (rst)
    (results.valid && results.data.all_last) |-> results.data.path_last)
    else $error("all_last without path_last");

endmodule

[tb/sv/sabr_euler_path_step_top_tb.sv]
`timescale 1ns / 100ps

module sabr_euler_path_step_top_tb;
  import sabr_pkg::*;

  localparam int unsigned RandomSteps = 1700;
  localparam int unsigned CycleLimit = 1500000;
  localparam int unsigned DrainCycles = 120;

  typedef struct {
    draw_t draw;
    logic  check_fixed;
    result_t fixed;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  sabr_if #(.payload_t(draw_t)) draws ();
  sabr_if #(.payload_t(result_t)) results ();
  sabr_if #(.payload_t(cfg_t)) cfg ();

  sabr_euler_path_step_top u_dut (
    .clk(clk),
    .rst(rst),
    .draws(draws.sink),
    .results(results.source),
    .cfg(cfg.sink)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic [31:0] init_fwd_q, init_vol_q, fwd_q, vol_q;
  logic [16:0] beta_q, scale_q;
  logic [19:0] nu_q;
  logic [15:0] steps_q, paths_q, step_idx_q, path_idx_q;

  result_t expected_steps[$];
  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;
  logic rx_stall_mode = 1'b0;

  const logic [31:0] exp2_k[16] = '{
    32'd1518500250, 32'd1276901417, 32'd1170923762, 32'd1121280436,
    32'd1097253709, 32'd1085434104, 32'd1079142639, 32'd1076653033,
    32'd1075196443, 32'd1074468888, 32'd1074105294, 32'd1073923544,
    32'd1073832680, 32'd1073787251, 32'd1073764537, 32'd1073753181
  };

  function automatic logic [63:0] clip32(input logic [63:0] v);
    return (v > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : v;
  endfunction

  function automatic logic [31:0] fwd_pow_beta(input logic [31:0] f, input logic [16:0] b);
    int lead;
    int n;
    int s;
    logic [63:0] x, u, v, acc;
    logic [31:0] b32;
    logic [15:0] fr;
    logic [31:0] frac;
    b32 = (b > BETA_ONE) ? 32'd65536 : {15'd0, b};
    if (f == 0) return (b32 == 0) ? 32'd65536 : 32'd0;
    lead = 31;
    while (f[lead] == 1'b0) lead--;
    x = 64'(f) << (31 - lead);
    frac = 0;
    for (int i = 0; i < 16; i++) begin
      x = (x * x) >> 31;
      frac = frac << 1;
      if (x >= 64'h1_0000_0000) begin
        x = x >> 1;
        frac[0] = 1'b1;
      end
    end
    u = 64'(lead) * 65536 + 64'(frac);
    v = ((u * 64'(b32)) >> 16) + (64'd1 << 20) - 64'd16 * 64'(b32);
    n = int'(v >> 16) - 16;
    fr = v[15:0];
    acc = 64'd1 << 30;
    for (int k = 0; k < 16; k++)
      if (fr[15-k]) acc = (acc * 64'(exp2_k[k])) >> 30;
    s = n - 14;
    if (s >= 0) begin
      if (s > 32) return 32'hFFFF_FFFF;
      return 32'(clip32(acc << s));
    end
    if (-s > 62) return 32'd0;
    return 32'(acc >> (-s));
  endfunction

  function automatic logic signed [63:0] drift(input logic [31:0] a, input logic [31:0] b,
                                               input logic signed [15:0] z);
    logic [63:0] m, mag, d;
    m = clip32((64'(a) * 64'(b)) >> 16);
    m = clip32((m * 64'(scale_q)) >> 16);
    mag = (z < 0) ? 64'(-32'(z)) : 64'(z);
    d = (m * mag) >> 12;
    return (z < 0) ? -$signed(d) : $signed(d);
  endfunction

  function automatic logic [31:0] settle(input logic [31:0] cur, input logic signed [63:0] d);
    logic signed [63:0] nx;
    nx = $signed(64'(cur)) + d;
    if (nx < 64'sd66) nx = 64'sd66;
    if (nx > 64'sh0_FFFF_FFFF) nx = 64'sh0_FFFF_FFFF;
    return nx[31:0];
  endfunction

  task automatic predictor_reset();
    init_fwd_q = 32'd65536;
    init_vol_q = 32'd13107;
    beta_q = 17'd32768;
    nu_q = 20'd26214;
    scale_q = 17'd6554;
    steps_q = 16'd100;
    paths_q = 16'd1;
    fwd_q = init_fwd_q;
    vol_q = init_vol_q;
    step_idx_q = 0;
    path_idx_q = 0;
  endtask

  task automatic predictor_write(input logic [CfgIdxW-1:0] idx, input logic [31:0] val);
    case (idx)
      REG_INIT_FWD: init_fwd_q = val;
      REG_INIT_VOL: init_vol_q = val;
      REG_BETA:     beta_q = val[16:0];
      REG_NU:       nu_q = val[19:0];
      REG_SCALE:    scale_q = val[16:0];
      REG_STEPS:    steps_q = val[15:0];
      REG_PATHS:    paths_q = val[15:0];
      default: ;
    endcase
  endtask

  function automatic result_t euler_step(input draw_t d);
    result_t r;
    logic [31:0] fb;
    logic plast, alast;
    fb = fwd_pow_beta(fwd_q, beta_q);
    r.forward_out = settle(fwd_q, drift(vol_q, fb, d.draw_forward));
    r.vol_out = settle(vol_q, drift({12'd0, nu_q}, vol_q, d.draw_vol));
    plast = (17'(step_idx_q) + 17'd1) >= 17'(steps_q);
    alast = plast && ((17'(path_idx_q) + 17'd1) >= 17'(paths_q));
    r.path_last = plast;
    r.all_last = alast;
    if (plast) begin
      fwd_q = init_fwd_q;
      vol_q = init_vol_q;
      step_idx_q = 0;
      path_idx_q = alast ? 16'd0 : path_idx_q + 16'd1;
    end else begin
      fwd_q = r.forward_out;
      vol_q = r.vol_out;
      step_idx_q = step_idx_q + 16'd1;
    end
    return r;
  endfunction

  // receiver: stall pattern alternates between a busy-stall mode and free run
  always @(negedge clk) begin
    if (rst) begin
      results.ready <= 1'b0;
    end else begin
      if ($urandom_range(0, 199) == 0) rx_stall_mode <= ~rx_stall_mode;
      results.ready <= rx_stall_mode ? ($urandom_range(0, 3) == 0) : 1'b1;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("sabr_euler_path_step_top_tb NOT OK");
      $finish;
    end
    if (!rst && results.valid && results.ready) begin
      if (expected_steps.size() == 0) begin
        $error("unexpected result forward_out=%0d", results.data.forward_out);
        fail_count++;
      end else begin
        result_t e;
        e = expected_steps.pop_front();
        if (results.data.forward_out !== e.forward_out) begin
          $error("forward_out expected %0d got %0d", e.forward_out, results.data.forward_out);
          fail_count++;
        end
        if (results.data.vol_out !== e.vol_out) begin
          $error("vol_out expected %0d got %0d", e.vol_out, results.data.vol_out);
          fail_count++;
        end
        if (results.data.path_last !== e.path_last) begin
          $error("path_last expected %0b got %0b", e.path_last, results.data.path_last);
          fail_count++;
        end
        if (results.data.all_last !== e.all_last) begin
          $error("all_last expected %0b got %0b", e.all_last, results.data.all_last);
          fail_count++;
        end
      end
    end
  end

  task automatic wait_drained();
    while (expected_steps.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [31:0] val);
    cfg.data <= '{index: idx, data: val};
    cfg.valid <= 1'b1;
    do @(posedge clk); while (!cfg.ready);
    predictor_write(idx, val);
    @(negedge clk);
    cfg.valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic send_draw(input draw_t d, input logic check_fixed, input result_t fixed);
    result_t r;
    draws.data <= d;
    draws.valid <= 1'b1;
    do @(posedge clk); while (!draws.ready);
    r = euler_step(d);
    if (check_fixed && r !== fixed) begin
      $error("step table expected %h predicted %h", fixed, r);
      fail_count++;
    end
    expected_steps.push_back(r);
  endtask

  // random gaps between bursts; valid held high inside a burst
  int unsigned burst_left = 0;
  task automatic pace();
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if ($urandom_range(0, 3) != 0) begin
        @(negedge clk);
        draws.valid <= 1'b0;
        repeat ($urandom_range(1, 60)) @(negedge clk);
        return;
      end
    end
    burst_left--;
    @(negedge clk);
  endtask

  function automatic draw_t rand_draw();
    draw_t d;
    case ($urandom_range(0, 5))
      0: d = $urandom;
      1: d = '{draw_forward: 16'sh7FFF, draw_vol: 16'sh8000};
      default: begin
        d.draw_forward = 16'($signed($urandom_range(0, 16384)) - 8192);
        d.draw_vol = 16'($signed($urandom_range(0, 16384)) - 8192);
      end
    endcase
    return d;
  endfunction

  stim_row_t steps_table[$];

  task automatic random_phase(input int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      send_draw(rand_draw(), 1'b0, '0);
      pace();
    end
    @(negedge clk);
    draws.valid <= 1'b0;
    wait_drained();
    repeat (DrainCycles) @(negedge clk);
  endtask

  initial begin
    draws.valid = 1'b0;
    draws.data = '0;
    cfg.valid = 1'b0;
    cfg.data = '0;
    predictor_reset();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // zero draws leave forward and vol at their reset values
    steps_table.push_back('{'{16'sd0, 16'sd0}, 1'b1, '{32'd65536, 32'd13107, 1'b0, 1'b0}});
    steps_table.push_back('{'{16'sh7FFF, 16'sh7FFF}, 1'b0, '0});
    steps_table.push_back('{'{16'sh8000, 16'sh8000}, 1'b0, '0});
    steps_table.push_back('{'{16'sh8000, 16'sh7FFF}, 1'b0, '0});
    steps_table.push_back('{'{16'sh5555, 16'shAAAA}, 1'b0, '0});
    steps_table.push_back('{'{-16'sd1, 16'sd1}, 1'b0, '0});
    foreach (steps_table[i]) begin
      send_draw(steps_table[i].draw, steps_table[i].check_fixed, steps_table[i].fixed);
      @(negedge clk);
    end
    draws.valid <= 1'b0;
    wait_drained();
    repeat (DrainCycles) @(negedge clk);

    // zero forward, beta zero, short paths with zero counts; the first
    // step ends the path and reloads the zero forward
    write_reg(REG_INIT_FWD, 32'd0);
    write_reg(REG_BETA, 32'd0);
    write_reg(REG_STEPS, 32'd0);
    write_reg(REG_PATHS, 32'd0);
    send_draw('{16'sd0, 16'sd0}, 1'b0, '0);
    @(negedge clk);
    send_draw('{16'sd0, 16'sd0}, 1'b1, '{32'd66, 32'd13107, 1'b1, 1'b1});
    @(negedge clk);
    send_draw('{16'sh7FFF, 16'sh8000}, 1'b0, '0);
    @(negedge clk);
    draws.valid <= 1'b0;
    wait_drained();
    repeat (DrainCycles) @(negedge clk);

    // extremes: max forward and vol, beta above one, max nu and scale
    write_reg(REG_INIT_FWD, 32'hFFFF_FFFF);
    write_reg(REG_INIT_VOL, 32'hFFFF_FFFF);
    write_reg(REG_BETA, 32'h1FFFF);
    write_reg(REG_NU, 32'hFFFFF);
    write_reg(REG_SCALE, 32'h1FFFF);
    write_reg(REG_STEPS, 32'd3);
    write_reg(REG_PATHS, 32'd2);
    random_phase(12);

    write_reg(REG_BETA, 32'd0);
    write_reg(REG_SCALE, 32'd0);
    write_reg(REG_INIT_VOL, 32'd0);
    random_phase(8);

    // random settings, mostly short paths
    for (int ph = 0; ph < 10; ph++) begin
      write_reg(REG_INIT_FWD, ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 1 << 20));
      write_reg(REG_INIT_VOL, ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 1 << 17));
      write_reg(REG_BETA, $urandom_range(0, 1 << 17));
      write_reg(REG_NU, $urandom_range(0, 20'hFFFFF));
      write_reg(REG_SCALE, $urandom_range(0, 65536));
      write_reg(REG_STEPS, (ph == 9) ? 32'hFFFF : $urandom_range(1, 20));
      write_reg(REG_PATHS, (ph == 8) ? 32'hFFFF : $urandom_range(1, 6));
      random_phase(RandomSteps / 10);
    end

    // lower counts mid-run after a drained pause
    write_reg(REG_STEPS, 32'd1);
    write_reg(REG_PATHS, 32'd1);
    random_phase(10);

    if (fail_count == 0) begin
      $display("sabr_euler_path_step_top_tb OK");
    end else begin
      $display("sabr_euler_path_step_top_tb NOT OK");
    end
    $finish;
  end

endmodule
